@@ rtl/dll_pkg.sv @@
// Package: shared constants and types for the doubly linked list engine.
`timescale 1ns / 1ps
`default_nettype none
package dll_pkg;
	localparam int CAPACITY = 32;
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [5:0] NIL = 6'd63;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_INSERT_AT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_POP_FRONT  = 3'd4;
	localparam logic [2:0] OP_REMOVE_AT  = 3'd5;
	localparam logic [2:0] OP_DUMP       = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// clamp a stored link to a legal node index
	function automatic logic [IW-1:0] fix(input logic [5:0] i);
		logic [IW-1:0] r;
		r = (i < 6'(CAPACITY)) ? i[IW-1:0] : '0;
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/doubly_linked_list_engine.sv @@
// Top level: doubly linked list engine with node memories and its sequencer.
//
// Use: one input channel (op, value, position) and one result channel
// (status, value_res, count, last), both valid/stall. The block takes one
// item, works on it alone, delivers its results, then takes the next.
// Edits give one result; dump gives one result per element, last on the
// final one (an empty dump gives one result with status empty).
// Steps: push front/back run the write states W1, W2, W3, then the result;
// pop front/back first read the end node (RD, WALK); a flagged error or an
// unused op goes straight to the result. Insert at / remove at walk the
// list one next-link read per node; dump reads, then delivers, each element.
// The walk is bound by the single read port of the link memory.
// Reset: head and tail go to the null marker, count to zero, free stack
// register holds every node index in order. Node memories need no clearing.
// Stall: a result sits in the output register until taken; the sequencer
// waits there, so nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module doubly_linked_list_engine
	import dll_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [2:0]  op,
	input  wire  signed [31:0] value,
	input  wire  [5:0]  position,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  status,
	output logic signed [31:0] value_res,
	output logic [5:0]  count,
	output logic        last
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_RD    = 10'b0000000010, // address applied, wait for read data
		S_WALK  = 10'b0000000100, // read data ready
		S_W1    = 10'b0000001000,
		S_W2    = 10'b0000010000,
		S_W3    = 10'b0000100000,
		S_DRD   = 10'b0001000000,
		S_DOUT  = 10'b0010000000,
		S_RES   = 10'b0100000000,
		S_WAIT  = 10'b1000000000
	} state_t;

	state_t st_q;
	logic [2:0] op_q;
	logic [31:0] val_q;
	logic [5:0] pos_q, step_q, cnt_q, head_q, tail_q, top_q;
	logic [IW-1:0] t_q, p_q, q_q, n_q;
	logic [IW-1:0] fstk_q [CAPACITY];

	// one shared port per memory
	logic nv_we, nx_we, pv_we;
	logic [IW-1:0] nv_a, nx_a, pv_a;
	logic [31:0] nv_wd, nv_rd;
	logic [5:0] nx_wd, pv_wd, nx_rd, pv_rd;

	dll_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val (.clk, .we(nv_we), .addr(nv_a),
		.wdata(nv_wd), .rdata(nv_rd));
	dll_ram #(.WIDTH(6), .DEPTH(CAPACITY)) u_nxt (.clk, .we(nx_we), .addr(nx_a),
		.wdata(nx_wd), .rdata(nx_rd));
	dll_ram #(.WIDTH(6), .DEPTH(CAPACITY)) u_prv (.clk, .we(pv_we), .addr(pv_a),
		.wdata(pv_wd), .rdata(pv_rd));

	// kind of edit, decided at S_IDLE-to-work transition
	typedef enum logic [5:0] {
		K_PF = 6'b000001, K_PB = 6'b000010, K_IM = 6'b000100,
		K_RF = 6'b001000, K_RB = 6'b010000, K_RM = 6'b100000
	} kind_t;
	kind_t kind_q;

	logic full, empty;
	assign full  = cnt_q >= 6'(CAPACITY);
	assign empty = cnt_q == '0;
	logic [IW-1:0] free_n;
	assign free_n = fstk_q[fix(top_q - 6'd1)];

	assign in_stall = st_q != S_IDLE;
	assign count = cnt_q;

	always_comb begin
		nv_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
		nv_a = t_q; nx_a = t_q; pv_a = t_q;
		nv_wd = val_q; nx_wd = NIL; pv_wd = NIL;
		case (st_q)
			S_W1: begin
				case (kind_q)
					K_PF: begin
						nv_we = 1'b1; nv_a = n_q;
						nx_we = 1'b1; nx_a = n_q; nx_wd = empty ? NIL : head_q;
						pv_we = 1'b1; pv_a = n_q; pv_wd = NIL;
					end
					K_PB: begin
						nv_we = 1'b1; nv_a = n_q;
						nx_we = 1'b1; nx_a = n_q; nx_wd = NIL;
						pv_we = 1'b1; pv_a = n_q; pv_wd = empty ? NIL : tail_q;
					end
					K_IM: begin
						nv_we = 1'b1; nv_a = n_q;
						nx_we = 1'b1; nx_a = n_q; nx_wd = 6'(t_q);
						pv_we = 1'b1; pv_a = n_q; pv_wd = 6'(p_q);
					end
					K_RF: begin
						pv_we = (cnt_q != 6'd1); pv_a = q_q; pv_wd = NIL;
					end
					K_RB: begin
						nx_we = (cnt_q != 6'd1); nx_a = p_q; nx_wd = NIL;
					end
					K_RM: begin
						nx_we = 1'b1; nx_a = p_q; nx_wd = 6'(q_q);
						pv_we = 1'b1; pv_a = q_q; pv_wd = 6'(p_q);
					end
					default: ;
				endcase
			end
			S_W2: begin
				case (kind_q)
					K_PF: begin pv_we = !empty; pv_a = fix(head_q); pv_wd = 6'(n_q); end
					K_PB: begin nx_we = !empty; nx_a = fix(tail_q); nx_wd = 6'(n_q); end
					K_IM: begin
						nx_we = 1'b1; nx_a = p_q; nx_wd = 6'(n_q);
						pv_we = 1'b1; pv_a = t_q; pv_wd = 6'(n_q);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			head_q <= NIL;
			tail_q <= NIL;
			top_q <= 6'(CAPACITY);
			out_valid <= 1'b0;
			kind_q <= K_PF;
			for (int i = 0; i < CAPACITY; i++) fstk_q[i] <= IW'(i);
		end else begin
			case (st_q)
				S_IDLE: if (in_valid) begin
					op_q <= op; val_q <= value; pos_q <= position; step_q <= '0;
					status <= ST_OK; value_res <= '0; last <= 1'b1;
					st_q <= S_RES;
					t_q <= fix(head_q);
					case (op)
						OP_PUSH_FRONT, OP_PUSH_BACK: if (full) status <= ST_FULL;
							else begin
								kind_q <= (op == OP_PUSH_FRONT) ? K_PF : K_PB;
								n_q <= free_n; st_q <= S_W1;
							end
						OP_INSERT_AT: if (full) status <= ST_FULL;
							else if (position > cnt_q) status <= ST_RANGE;
							else if (position == '0) begin
								kind_q <= K_PF; n_q <= free_n; st_q <= S_W1;
							end else if (position == cnt_q) begin
								kind_q <= K_PB; n_q <= free_n; st_q <= S_W1;
							end else begin
								kind_q <= K_IM; n_q <= free_n; st_q <= S_RD;
							end
						OP_POP_BACK: if (empty) status <= ST_EMPTY;
							else begin kind_q <= K_RB; t_q <= fix(tail_q); st_q <= S_RD; end
						OP_POP_FRONT: if (empty) status <= ST_EMPTY;
							else begin kind_q <= K_RF; st_q <= S_RD; end
						OP_REMOVE_AT: if (empty) status <= ST_EMPTY;
							else if (position >= cnt_q) status <= ST_RANGE;
							else if (position == '0) begin kind_q <= K_RF; st_q <= S_RD; end
							else if (position == cnt_q - 6'd1) begin
								kind_q <= K_RB; t_q <= fix(tail_q); st_q <= S_RD;
							end else begin kind_q <= K_RM; st_q <= S_RD; end
						OP_DUMP: if (empty) status <= ST_EMPTY;
							else st_q <= S_DRD;
						default: ;
					endcase
				end
				S_RD: st_q <= S_WALK;
				S_WALK: begin
					// walk forward until pos steps done, then capture neighbors
					if ((kind_q == K_IM || kind_q == K_RM) && step_q != pos_q) begin
						t_q <= fix(nx_rd); step_q <= step_q + 6'd1; st_q <= S_RD;
					end else begin
						p_q <= fix(pv_rd); q_q <= fix(nx_rd); st_q <= S_W1;
					end
				end
				S_W1: st_q <= S_W2;
				S_W2: st_q <= S_W3;
				S_W3: begin
					case (kind_q)
						K_PF, K_PB, K_IM: begin
							top_q <= top_q - 6'd1;
							cnt_q <= cnt_q + 6'd1;
							if (kind_q == K_PF) begin
								head_q <= 6'(n_q); if (empty) tail_q <= 6'(n_q);
							end
							if (kind_q == K_PB) begin
								tail_q <= 6'(n_q); if (empty) head_q <= 6'(n_q);
							end
						end
						default: begin
							fstk_q[top_q[IW-1:0]] <= t_q;
							top_q <= top_q + 6'd1;
							cnt_q <= cnt_q - 6'd1;
							if (kind_q == K_RF) begin
								head_q <= (cnt_q == 6'd1) ? NIL : 6'(q_q);
								if (cnt_q == 6'd1) tail_q <= NIL;
							end
							if (kind_q == K_RB) begin
								tail_q <= (cnt_q == 6'd1) ? NIL : 6'(p_q);
								if (cnt_q == 6'd1) head_q <= NIL;
							end
						end
					endcase
					st_q <= S_RES;
				end
				S_DRD: st_q <= S_DOUT;
				S_DOUT: begin
					value_res <= nv_rd;
					last <= (step_q + 6'd1 == cnt_q);
					t_q <= fix(nx_rd);
					step_q <= step_q + 6'd1;
					out_valid <= 1'b1;
					st_q <= S_WAIT;
				end
				S_RES: begin out_valid <= 1'b1; st_q <= S_WAIT; end
				S_WAIT: if (!out_stall) begin
					out_valid <= 1'b0;
					st_q <= (op_q == OP_DUMP && !last) ? S_DRD : S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// count never exceeds capacity
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 6'(CAPACITY)) else $error("count overflow");
	// free nodes plus elements equal capacity while idle
	a_cons: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_IDLE |-> (top_q + cnt_q) == 6'(CAPACITY)) else $error("node leak");
	// no input accepted while a result is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("overlap");
endmodule
`default_nettype wire

@@ rtl/dll_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module dll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] addr,
	input  wire [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

@@ verif/tb_doubly_linked_list_engine.sv @@
// Testbench: directed and randomized op traffic against a linked list model with a result scoreboard.
`timescale 1ns / 1ps
`default_nettype none

class list_scoreboard;
	// expected result fields, oldest first
	logic [1:0] exp_status[$];
	logic [31:0] exp_value[$];
	logic [5:0] exp_count[$];
	logic exp_last[$];
	int errors;

	// shadow list kept as a plain queue of values, head first
	logic [31:0] items[$];

	function new();
		errors = 0;
	endfunction

	function void push_expect(logic [1:0] st, logic [31:0] v, logic last);
		exp_status.push_back(st);
		exp_value.push_back(v);
		exp_count.push_back(6'(items.size()));
		exp_last.push_back(last);
	endfunction

	// note one accepted transfer on the input side and predict its results
	function void note_input(logic [2:0] op, logic [31:0] v, logic [5:0] pos);
		int n;
		logic full, empty;
		n = items.size();
		full = (n >= dll_pkg::CAPACITY);
		empty = (n == 0);
		case (op)
			dll_pkg::OP_PUSH_FRONT: begin
				if (full) push_expect(dll_pkg::ST_FULL, 0, 1);
				else begin
					items.push_front(v);
					push_expect(dll_pkg::ST_OK, 0, 1);
				end
			end
			dll_pkg::OP_PUSH_BACK: begin
				if (full) push_expect(dll_pkg::ST_FULL, 0, 1);
				else begin
					items.push_back(v);
					push_expect(dll_pkg::ST_OK, 0, 1);
				end
			end
			dll_pkg::OP_INSERT_AT: begin
				if (full) push_expect(dll_pkg::ST_FULL, 0, 1);
				else if (pos > n) push_expect(dll_pkg::ST_RANGE, 0, 1);
				else begin
					items.insert(pos, v);
					push_expect(dll_pkg::ST_OK, 0, 1);
				end
			end
			dll_pkg::OP_POP_BACK: begin
				if (empty) push_expect(dll_pkg::ST_EMPTY, 0, 1);
				else begin
					void'(items.pop_back());
					push_expect(dll_pkg::ST_OK, 0, 1);
				end
			end
			dll_pkg::OP_POP_FRONT: begin
				if (empty) push_expect(dll_pkg::ST_EMPTY, 0, 1);
				else begin
					void'(items.pop_front());
					push_expect(dll_pkg::ST_OK, 0, 1);
				end
			end
			dll_pkg::OP_REMOVE_AT: begin
				if (empty) push_expect(dll_pkg::ST_EMPTY, 0, 1);
				else if (pos >= n) push_expect(dll_pkg::ST_RANGE, 0, 1);
				else begin
					items.delete(pos);
					push_expect(dll_pkg::ST_OK, 0, 1);
				end
			end
			dll_pkg::OP_DUMP: begin
				if (empty) push_expect(dll_pkg::ST_EMPTY, 0, 1);
				else
					for (int k = 0; k < n; k++)
						push_expect(dll_pkg::ST_OK, items[k], k == n - 1);
			end
			default: push_expect(dll_pkg::ST_OK, 0, 1);
		endcase
	endfunction

	// compare one accepted result against the oldest expectation
	function void check_result(logic [1:0] st, logic [31:0] v, logic [5:0] c, logic l);
		if (exp_status.size() == 0) begin
			$error("unexpected result status=%0d value_res=%0d count=%0d last=%0d",
				st, $signed(v), c, l);
			errors++;
			return;
		end
		if (st !== exp_status[0]) begin
			$error("status: expected %0d, got %0d", exp_status[0], st);
			errors++;
		end
		if (v !== exp_value[0]) begin
			$error("value_res: expected %0d, got %0d", $signed(exp_value[0]), $signed(v));
			errors++;
		end
		if (c !== exp_count[0]) begin
			$error("count: expected %0d, got %0d", exp_count[0], c);
			errors++;
		end
		if (l !== exp_last[0]) begin
			$error("last: expected %0d, got %0d", exp_last[0], l);
			errors++;
		end
		void'(exp_status.pop_front());
		void'(exp_value.pop_front());
		void'(exp_count.pop_front());
		void'(exp_last.pop_front());
	endfunction

	function int pending();
		return exp_status.size();
	endfunction

	function int depth();
		return items.size();
	endfunction
endclass

module tb_doubly_linked_list_engine;
	import dll_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [2:0] op = '0;
	logic signed [31:0] value = '0;
	logic [5:0] position = '0;
	logic out_valid;
	logic out_stall = 1;
	logic [1:0] status;
	logic signed [31:0] value_res;
	logic [5:0] count;
	logic last;

	list_scoreboard board;
	int cycles = 0;
	bit stim_done = 0;

	doubly_linked_list_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .value(value), .position(position),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .value_res(value_res), .count(count), .last(last)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side: sample at the edge, then draw a fresh stall for the next cycle.
	// A random stall gap is drawn after each accepted result.
	int out_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_result(status, value_res, count, last);
			if (out_gap > 0) begin
				out_stall <= 1;
				out_gap <= out_gap - 1;
			end else if (out_valid && !out_stall) begin
				// a transfer just happened: pick the wait before the next one
				out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
				out_stall <= 0;
			end else
				out_stall <= 0;
		end
	end

	// one input transfer: idle for a drawn gap, then hold valid until taken.
	// Valid stays high after a transfer when the next item follows with no gap.
	task automatic send_item(input logic [2:0] o, input logic [31:0] v, input logic [5:0] p);
		int gap;
		gap = $urandom_range(0, 3);
		repeat (gap) begin
			in_valid <= 0;
			@(posedge clk);
		end
		op <= o;
		value <= v;
		position <= p;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		board.note_input(o, v, p);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// random op biased toward growth or shrinkage by the caller's bias, so it sweeps empty to full and back
	task automatic random_item(input int bias);
		int n, r;
		logic [2:0] o;
		logic [5:0] p;
		n = board.depth();
		r = $urandom_range(0, 99);
		if (r < 5) o = OP_DUMP;
		else if (r < 7) o = 3'd7;
		else if (r < 52 + bias) o = 3'($urandom_range(0, 2));
		else o = 3'($urandom_range(3, 5));
		// positions mostly legal, sometimes out of range or wild
		case ($urandom_range(0, 9))
			0: p = 6'($urandom);
			1: p = 6'(n);
			2: p = 0;
			default: p = 6'($urandom_range(0, n));
		endcase
		send_item(o, rand_value(), p);
	endtask

	initial begin
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty cases, unused op, edges, range errors, fill to full
		send_item(OP_POP_BACK, 0, 0);
		send_item(OP_POP_FRONT, 0, 0);
		send_item(OP_REMOVE_AT, 0, 0);
		send_item(OP_DUMP, 0, 0);
		send_item(3'd7, 32'hffff_ffff, 6'h3f);
		send_item(OP_INSERT_AT, 32'h8000_0000, 1);
		send_item(OP_PUSH_FRONT, 32'h7fff_ffff, 0);
		send_item(OP_POP_FRONT, 0, 0);            // single element: head and tail cleared
		send_item(OP_PUSH_BACK, 32'h8000_0000, 6'h3f);
		send_item(OP_POP_BACK, 0, 0);
		send_item(OP_INSERT_AT, 32'd1, 0);        // insert at 0 on empty
		send_item(OP_INSERT_AT, 32'd2, 1);        // insert at count
		send_item(OP_INSERT_AT, 32'hffff_ffff, 1);// middle
		send_item(OP_REMOVE_AT, 0, 3);            // at count: out of range
		send_item(OP_REMOVE_AT, 0, 1);            // middle
		send_item(OP_REMOVE_AT, 0, 1);            // count-1
		send_item(OP_DUMP, 0, 0);
		while (board.depth() < CAPACITY)
			send_item(OP_INSERT_AT, rand_value(), 6'($urandom_range(0, board.depth())));
		send_item(OP_PUSH_FRONT, 1, 0);
		send_item(OP_PUSH_BACK, 1, 0);
		send_item(OP_INSERT_AT, 1, 6'h3f);        // full beats bad position
		send_item(OP_DUMP, 0, 0);
		send_item(OP_REMOVE_AT, 0, 31);
		send_item(OP_REMOVE_AT, 0, 0);
		send_item(OP_INSERT_AT, 5, 32);

		// random: alternate growing and shrinking phases
		for (int i = 0; i < 325; i++)
			random_item(((i / 60) % 2) ? -25 : 25);
		in_valid <= 0;

		while (board.pending() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire

@@ doubly_linked_list_engine.f @@
rtl/dll_pkg.sv
rtl/dll_ram.sv
rtl/doubly_linked_list_engine.sv
verif/tb_doubly_linked_list_engine.sv
